>>> hw/rtl/mrmt_pkg.sv
`default_nettype none

package mrmt_pkg;

	localparam int PAGE_W = 52;
	localparam int ADDR_W = 64;
	localparam int KIND_W = 32;
	localparam int CMD_W  = 3;
	localparam int ENT_W  = 5;
	localparam int ALU_W  = 65;

	localparam logic [ADDR_W-1:0] ONE_MB          = 64'h0000_0000_0010_0000;
	localparam logic [12:0]       PAGE_BYTES      = 13'h1000;
	localparam logic [PAGE_W-1:0] LOW_START_LIMIT = 52'h100;
	localparam logic [KIND_W-1:0] KIND_USABLE     = 32'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_P2L    = 3'd1,
		CMD_L2P    = 3'd2,
		CMD_NEXT   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_IGNORED   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_END,
		S_INS_LEN,
		S_INS_FIRST,
		S_INS_LOW,
		S_INS_SRCH,
		S_INS_SHIFT,
		S_INS_WRITE,
		S_P2L_CMP,
		S_P2L_LEN,
		S_P2L_ADD,
		S_L2P_CMP,
		S_L2P_ADD,
		S_NXT_CMP,
		S_NXT_LEN,
		S_NXT_INC,
		S_NXT_START,
		S_FIN
	} state_t;

	// operands for the shared adder: a + (sub ? ~b : b) + cin
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
		logic             cin;
	} alu_req_t;

	// finished request handed to the output register
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		status_t           status;
		logic [ENT_W-1:0]  entries;
	} fin_t;

endpackage

`default_nettype wire

>>> hw/rtl/mrmt_ram.sv
`default_nettype none

module mrmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and a write in the same cycle return old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/mrmt_alu.sv
`default_nettype none

module mrmt_alu
	import mrmt_pkg::*;
(
	input  wire alu_req_t    req,
	output logic [ALU_W-1:0] res
);

	logic [ALU_W-1:0] b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign res   = req.a + b_eff + ALU_W'(req.cin);

endmodule

`default_nettype wire

>>> hw/rtl/mrmt_seq.sv
`default_nettype none

module mrmt_seq
	import mrmt_pkg::*;
#(
	parameter int MAX_REGIONS = 16,
	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
	localparam int CW = $clog2(MAX_REGIONS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request side
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cmd_t              in_cmd,
	input  wire logic [PAGE_W-1:0] in_page,
	input  wire logic [ADDR_W-1:0] in_base,
	input  wire logic [ADDR_W-1:0] in_bytes,
	input  wire logic [KIND_W-1:0] in_kind,
	// region table, word is {length, start}
	output logic                   ram_wr_en,
	output logic [IW-1:0]          ram_wr_addr,
	output logic [2*PAGE_W-1:0]    ram_wr_data,
	output logic [IW-1:0]          ram_rd_addr,
	input  wire logic [2*PAGE_W-1:0] ram_rd_data,
	// shared adder
	output alu_req_t               alu_req,
	input  wire logic [ALU_W-1:0]  alu_res,
	// finished request
	output fin_t                   fin,
	input  wire logic              fin_ready
);

	state_t state_q, state_d;

	logic [IW-1:0]     idx_q, idx_d;
	logic [IW-1:0]     pos_q;
	logic [CW-1:0]     count_q;

	logic [PAGE_W-1:0] p_q;
	logic [PAGE_W-1:0] acc_q;
	logic [PAGE_W-1:0] diff_q;
	logic              hit_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] bytes_q;
	logic              kind_ok_q;
	logic [PAGE_W-1:0] first_q;
	logic [PAGE_W-1:0] len_q;
	logic [PAGE_W-1:0] res_page_q;
	status_t           stat_q;

	logic [PAGE_W-1:0] rd_start;
	logic [PAGE_W-1:0] rd_len;
	logic              neg;
	logic              ones;
	logic              last;
	logic              empty;
	logic              full;
	logic              unal;
	logic [12:0]       shard;
	logic              bytes_small;
	logic              end_low;
	logic              ins_ignore;
	logic              low_start;
	logic              accept;

	assign rd_start = ram_rd_data[PAGE_W-1:0];
	assign rd_len   = ram_rd_data[2*PAGE_W-1:PAGE_W];

	assign neg   = alu_res[ALU_W-1];
	assign ones  = &alu_res;
	assign last  = (CW'(idx_q) + CW'(1)) >= count_q;
	assign empty = (count_q == '0);
	assign full  = (count_q >= CW'(MAX_REGIONS));

	// insert preprocessing: page rounding and the ignore rules
	assign unal        = |base_q[11:0];
	assign shard       = unal ? (PAGE_BYTES - {1'b0, base_q[11:0]}) : '0;
	assign bytes_small = (bytes_q[ADDR_W-1:13] == '0) && (bytes_q[12:0] <= shard);
	assign end_low     = !alu_res[ADDR_W] && (alu_res[ADDR_W-1:0] <= ONE_MB);
	assign ins_ignore  = !kind_ok_q || end_low || (unal && (bytes_small || &base_q[ADDR_W-1:12]));
	assign low_start   = (first_q <= LOW_START_LIMIT);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign fin.valid   = (state_q == S_FIN);
	assign fin.page    = res_page_q;
	assign fin.status  = stat_q;
	assign fin.entries = ENT_W'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_INSERT: state_d = S_INS_END;
						CMD_P2L:    state_d = empty ? S_FIN : S_P2L_CMP;
						CMD_L2P:    state_d = empty ? S_FIN : S_L2P_CMP;
						CMD_NEXT:   state_d = empty ? S_FIN : S_NXT_CMP;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_INS_END:   state_d = ins_ignore ? S_FIN : S_INS_LEN;
			S_INS_LEN:   state_d = S_INS_FIRST;
			S_INS_FIRST: state_d = S_INS_LOW;
			S_INS_LOW: begin
				if (full) begin
					state_d = S_FIN;
				end else if (empty) begin
					state_d = S_INS_WRITE;
				end else begin
					state_d = S_INS_SRCH;
				end
			end
			S_INS_SRCH: begin
				if (neg) begin
					state_d = S_INS_SHIFT;
				end else if (last) begin
					state_d = S_INS_WRITE;
				end
			end
			S_INS_SHIFT: begin
				if (idx_q == pos_q) begin
					state_d = S_INS_WRITE;
				end
			end
			S_INS_WRITE: state_d = S_FIN;
			S_P2L_CMP:   state_d = neg ? S_FIN : S_P2L_LEN;
			S_P2L_LEN:   state_d = S_P2L_ADD;
			S_P2L_ADD:   state_d = (hit_q || last) ? S_FIN : S_P2L_CMP;
			S_L2P_CMP: begin
				if (neg) begin
					state_d = S_L2P_ADD;
				end else if (last) begin
					state_d = S_FIN;
				end
			end
			S_L2P_ADD: state_d = S_FIN;
			S_NXT_CMP: begin
				if (!neg) begin
					state_d = S_NXT_LEN;
				end else if (last) begin
					state_d = S_FIN;
				end
			end
			S_NXT_LEN: begin
				if (!neg) begin
					state_d = last ? S_FIN : S_NXT_CMP;
				end else if (!ones) begin
					state_d = S_NXT_INC;
				end else begin
					state_d = last ? S_FIN : S_NXT_START;
				end
			end
			S_NXT_INC:   state_d = S_FIN;
			S_NXT_START: state_d = S_FIN;
			S_FIN: begin
				if (fin_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: adder operands, table access, walk index
	always_comb begin
		alu_req     = '0;
		idx_d       = idx_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = {len_q, first_q};
		case (state_q)
			S_IDLE: idx_d = '0;
			S_INS_END: begin
				alu_req.a = ALU_W'(base_q);
				alu_req.b = ALU_W'(bytes_q);
			end
			S_INS_LEN: begin
				alu_req.a   = ALU_W'(bytes_q);
				alu_req.b   = ALU_W'(shard);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
			end
			S_INS_FIRST: begin
				alu_req.a   = ALU_W'(base_q[ADDR_W-1:12]);
				alu_req.cin = unal;
			end
			S_INS_LOW: begin
				alu_req.a = ALU_W'(len_q);
				alu_req.b = ALU_W'(first_q);
			end
			S_INS_SRCH: begin
				alu_req.a   = ALU_W'(first_q);
				alu_req.b   = ALU_W'(rd_start);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
				if (neg) begin
					idx_d = IW'(count_q - CW'(1));
				end else if (!last) begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_INS_SHIFT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = idx_q + IW'(1);
				ram_wr_data = ram_rd_data;
				if (idx_q != pos_q) begin
					idx_d = idx_q - IW'(1);
				end
			end
			S_INS_WRITE: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = pos_q;
			end
			S_P2L_CMP: begin
				alu_req.a   = ALU_W'(p_q);
				alu_req.b   = ALU_W'(rd_start);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
			end
			S_P2L_LEN: begin
				alu_req.a   = ALU_W'(diff_q);
				alu_req.b   = ALU_W'(rd_len);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
			end
			S_P2L_ADD: begin
				alu_req.a = ALU_W'(acc_q);
				alu_req.b = hit_q ? ALU_W'(diff_q) : ALU_W'(rd_len);
				if (!hit_q && !last) begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_L2P_CMP: begin
				alu_req.a   = ALU_W'(acc_q);
				alu_req.b   = ALU_W'(rd_len);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
				if (!neg && !last) begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_L2P_ADD: begin
				alu_req.a = ALU_W'(rd_start);
				alu_req.b = ALU_W'(acc_q);
			end
			S_NXT_CMP: begin
				alu_req.a   = ALU_W'(p_q);
				alu_req.b   = ALU_W'(rd_start);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
				if (neg && !last) begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_NXT_LEN: begin
				alu_req.a   = ALU_W'(diff_q);
				alu_req.b   = ALU_W'(rd_len);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
				// outside the region, or on its last page: move to the next entry
				if ((!neg || ones) && !last) begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_NXT_INC: begin
				alu_req.a   = ALU_W'(p_q);
				alu_req.cin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ram_rd_addr = idx_d;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (accept && (in_cmd == CMD_CLEAR)) begin
				count_q <= '0;
			end else if (state_q == S_INS_WRITE) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					p_q        <= in_page;
					acc_q      <= (in_cmd == CMD_L2P) ? in_page : '0;
					base_q     <= in_base;
					bytes_q    <= in_bytes;
					kind_ok_q  <= (in_kind == KIND_USABLE);
					res_page_q <= '0;
					case (in_cmd)
						CMD_INSERT, CMD_CLEAR:      stat_q <= STAT_OK;
						CMD_P2L, CMD_L2P, CMD_NEXT: stat_q <= STAT_NOT_FOUND;
						default:                    stat_q <= STAT_IGNORED;
					endcase
				end
			end
			S_INS_END: begin
				if (ins_ignore) begin
					stat_q <= STAT_IGNORED;
				end
			end
			S_INS_LEN:   len_q   <= alu_res[ADDR_W-1:12];
			S_INS_FIRST: first_q <= alu_res[PAGE_W-1:0];
			S_INS_LOW: begin
				pos_q <= '0;
				if (low_start) begin
					len_q   <= alu_res[PAGE_W] ? '1 : alu_res[PAGE_W-1:0];
					first_q <= '0;
				end
				if (full) begin
					stat_q <= STAT_FULL;
				end
			end
			S_INS_SRCH: begin
				if (neg) begin
					pos_q <= idx_q;
				end else if (last) begin
					pos_q <= IW'(count_q);
				end
			end
			S_INS_WRITE: stat_q <= STAT_OK;
			S_P2L_CMP:   diff_q <= alu_res[PAGE_W-1:0];
			S_P2L_LEN:   hit_q  <= neg;
			S_P2L_ADD: begin
				if (hit_q) begin
					res_page_q <= alu_res[PAGE_W-1:0];
					stat_q     <= STAT_OK;
				end else begin
					acc_q <= alu_res[PAGE_W-1:0];
				end
			end
			S_L2P_CMP: begin
				if (!neg) begin
					acc_q <= alu_res[PAGE_W-1:0];
				end
			end
			S_L2P_ADD, S_NXT_INC: begin
				res_page_q <= alu_res[PAGE_W-1:0];
				stat_q     <= STAT_OK;
			end
			S_NXT_CMP: diff_q <= alu_res[PAGE_W-1:0];
			S_NXT_START: begin
				res_page_q <= rd_start;
				stat_q     <= STAT_OK;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count above table size");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WRITE) |-> (count_q < CW'(MAX_REGIONS)))
		else $error("insert write into a full table");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_SHIFT) |-> (idx_q >= pos_q))
		else $error("shift walked below the insert position");

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WRITE) |=> ((count_q == $past(count_q) + CW'(1))
			&& (state_q == S_FIN)))
		else $error("insert did not bump the region count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/memory_region_map_translator.sv
`default_nettype none

// Usable-memory region table and page translator. Insert requests (tuser 0) take a memory-map
// record; it is kept only if its kind is 1 and it ends above 1 MB, its start is rounded up to a
// 4 KB page, a start at or below page 0x100 is pulled down to page 0, and the region goes into
// the table sorted by start page (after equal starts). Query requests translate a physical page
// to its place in the packed linear page space (1), a linear page back to physical (2), or give
// the next usable physical page (3); request 4 empties the table. Every request returns exactly
// one result with a status (0 ok, 1 ignored, 2 full, 3 not found), result page 0 unless ok, and
// the region count afterward. One request is worked at a time, and s_tready is low until its
// result has moved into the output register; that register lets the next request in while the
// result waits for m_tready. An insert runs four preparation steps, a search up to the slot, a
// shift of the entries behind it, a write and the hand-off; a dropped insert ends after the first
// preparation step and an insert into a full table after the fourth. Lookups walk the table from
// its first entry; a lookup on an empty table, a clear or an unknown request goes straight to the
// hand-off. s_tready rises again at the edge that loads the output register, which waits while
// that register still holds a result not yet taken by m_tready.
// Every arithmetic step uses the single 65-bit adder, and the region table has one read port
// and is walked one entry at a time. Stored regions survive a clear but are never read again
// until rewritten.

module memory_region_map_translator
	import mrmt_pkg::*;
#(
	parameter int MAX_REGIONS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// page_number[51:0], region_base[115:52], region_bytes[179:116], region_kind[211:180]
	input  wire logic [215:0] s_tdata,
	// cmd[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_page[51:0], entries_used[56:52]
	output logic [63:0]       m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	logic                  ram_wr_en;
	logic [IW-1:0]         ram_wr_addr;
	logic [2*PAGE_W-1:0]   ram_wr_data;
	logic [IW-1:0]         ram_rd_addr;
	logic [2*PAGE_W-1:0]   ram_rd_data;

	alu_req_t              alu_req;
	logic [ALU_W-1:0]      alu_res;

	fin_t                  fin;
	logic                  fin_ready;

	// output register
	logic                  m_valid_q;
	logic [PAGE_W-1:0]     m_page_q;
	status_t               m_stat_q;
	logic [ENT_W-1:0]      m_ent_q;

	assign fin_ready = !m_valid_q || m_tready;

	mrmt_seq #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (cmd_t'(s_tuser)),
		.in_page     (s_tdata[51:0]),
		.in_base     (s_tdata[115:52]),
		.in_bytes    (s_tdata[179:116]),
		.in_kind     (s_tdata[211:180]),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.alu_req     (alu_req),
		.alu_res     (alu_res),
		.fin         (fin),
		.fin_ready   (fin_ready)
	);

	// region table: {length pages, start pages} per entry
	mrmt_ram #(
		.WIDTH(2 * PAGE_W),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	mrmt_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin.valid && fin_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && fin_ready) begin
			m_page_q <= fin.page;
			m_stat_q <= fin.status;
			m_ent_q  <= fin.entries;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, m_ent_q, m_page_q};
	assign m_tuser  = m_stat_q;

endmodule

`default_nettype wire

>>> tb/sv/memory_region_map_translator_test.sv
`timescale 1ns / 100ps

module memory_region_map_translator_test;
	import mrmt_pkg::*;

	localparam int          MAX_REGIONS = 16;
	localparam logic [63:0] PAGE_MASK   = {12'b0, {PAGE_W{1'b1}}};

	// one request as the sender sees it; cmd stays raw so 5..7 can be sent
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PAGE_W-1:0] page;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] bytes;
		logic [KIND_W-1:0] kind;
	} map_req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		status_t           status;
		logic [ENT_W-1:0]  entries;
	} map_reply_t;

	bit           clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;

	memory_region_map_translator #(.MAX_REGIONS(MAX_REGIONS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// predicted region table
	logic [63:0] tbl_start [MAX_REGIONS];
	logic [63:0] tbl_len   [MAX_REGIONS];
	int unsigned tbl_count = 0;

	map_req_t    cmd_q[$];
	map_reply_t  reply_q[$];
	map_req_t    cur_req;
	int unsigned put_cnt = 0;
	int unsigned acc_cnt = 0;
	int unsigned done_cnt = 0;
	bit          failed = 1'b0;

	// no idling on either side over this stretch of requests / results
	localparam int unsigned CALM_LO = 900;
	localparam int unsigned CALM_HI = 1200;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// Applies one request to the predicted table and returns the reply it must produce.
	function automatic map_reply_t region_table_reply(map_req_t r);
		map_reply_t  o;
		logic [63:0] b, n, stop, shard, first, len, acc, e, p;
		int unsigned pos;
		bit          done, keep;
		o.page   = '0;
		o.status = STAT_IGNORED;
		done     = 1'b0;
		keep     = 1'b1;
		acc      = '0;
		p        = 64'(r.page);
		case (r.cmd)
			CMD_INSERT: begin
				b    = r.base;
				n    = r.bytes;
				stop = b + n;
				// unusable kind, or ends at/below 1 MB without wrapping
				if (r.kind != KIND_USABLE || (stop >= b && stop <= ONE_MB))
					keep = 1'b0;
				else if (b[11:0] != 12'h0) begin
					shard = 64'(PAGE_BYTES) - 64'(b[11:0]);
					if (n <= shard || b + shard < b)
						keep = 1'b0;
					else begin
						b = b + shard;
						n = n - shard;
					end
				end
				if (keep) begin
					first = b >> 12;
					len   = n >> 12;
					if (first <= 64'(LOW_START_LIMIT)) begin
						len = len + first;
						if (len > PAGE_MASK)
							len = PAGE_MASK;
						first = '0;
					end
					if (tbl_count >= MAX_REGIONS)
						o.status = STAT_FULL;
					else begin
						// slot goes after any equal start
						pos = tbl_count;
						for (int i = 0; i < tbl_count && pos == tbl_count; i++)
							if (tbl_start[i] > first)
								pos = i;
						for (int i = tbl_count; i > pos; i--) begin
							tbl_start[i] = tbl_start[i-1];
							tbl_len[i]   = tbl_len[i-1];
						end
						tbl_start[pos] = first;
						tbl_len[pos]   = len;
						tbl_count++;
						o.status = STAT_OK;
					end
				end
			end
			CMD_P2L: begin
				o.status = STAT_NOT_FOUND;
				for (int i = 0; i < tbl_count && !done; i++) begin
					if (tbl_start[i] > p)
						done = 1'b1;
					else if (tbl_start[i] + tbl_len[i] > p) begin
						e        = acc + p - tbl_start[i];
						o.page   = e[PAGE_W-1:0];
						o.status = STAT_OK;
						done     = 1'b1;
					end else
						acc = acc + tbl_len[i];
				end
			end
			CMD_L2P: begin
				o.status = STAT_NOT_FOUND;
				acc      = p;
				for (int i = 0; i < tbl_count && !done; i++) begin
					if (acc < tbl_len[i]) begin
						e        = tbl_start[i] + acc;
						o.page   = e[PAGE_W-1:0];
						o.status = STAT_OK;
						done     = 1'b1;
					end else
						acc = acc - tbl_len[i];
				end
			end
			CMD_NEXT: begin
				o.status = STAT_NOT_FOUND;
				for (int i = 0; i < tbl_count && !done; i++) begin
					e = tbl_start[i] + tbl_len[i];
					if (tbl_start[i] <= p && p < e) begin
						done = 1'b1;
						if (p < e - 64'd1) begin
							acc      = p + 64'd1;
							o.page   = acc[PAGE_W-1:0];
							o.status = STAT_OK;
						end else if (i + 1 < tbl_count) begin
							o.page   = tbl_start[i+1][PAGE_W-1:0];
							o.status = STAT_OK;
						end
					end
				end
			end
			CMD_CLEAR: begin
				tbl_count = 0;
				o.status  = STAT_OK;
			end
			default: o.status = STAT_IGNORED;
		endcase
		if (o.status != STAT_OK)
			o.page = '0;
		o.entries = tbl_count[ENT_W-1:0];
		return o;
	endfunction

	task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
			input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] bytes,
			input logic [KIND_W-1:0] kind);
		map_req_t r;
		r.cmd   = cmd;
		r.page  = page;
		r.base  = base;
		r.bytes = bytes;
		r.kind  = kind;
		cmd_q.push_back(r);
	endtask

	// Driver: presents the next pending request at the falling edge, holds it until taken.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && acc_cnt != put_cnt)) begin
			if (cmd_q.size() != 0 &&
					((put_cnt >= CALM_LO && put_cnt < CALM_HI) || $urandom_range(99) >= 23)) begin
				cur_req = cmd_q.pop_front();
				s_tdata  <= {4'b0, cur_req.kind, cur_req.bytes, cur_req.base, cur_req.page};
				s_tuser  <= cur_req.cmd;
				s_tvalid <= 1'b1;
				put_cnt++;
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		m_tready <= (done_cnt >= CALM_LO && done_cnt < CALM_HI) || $urandom_range(99) >= 23;
	end

	// Monitor: checks each result against the oldest prediction, then predicts
	// for a request taken at this edge.
	always @(posedge clk) begin
		map_reply_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				done_cnt++;
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected result page %h status %0d entries %0d", $time,
						m_tdata[51:0], m_tuser, m_tdata[56:52]);
					failed = 1'b1;
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[51:0] !== want.page || m_tuser !== want.status ||
							m_tdata[56:52] !== want.entries) begin
						$display({"%0t: expected page %h status %0d entries %0d, ",
							"got page %h status %0d entries %0d"},
							$time, want.page, want.status, want.entries,
							m_tdata[51:0], m_tuser, m_tdata[56:52]);
						failed = 1'b1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				reply_q.push_back(region_table_reply(cur_req));
				acc_cnt++;
			end
		end
	end

	initial begin
		logic [63:0] aim_start[$];
		logic [63:0] aim_len[$];
		logic [63:0] lin_total, bp, np, r64;
		logic [PAGE_W-1:0] pg;
		logic [CMD_W-1:0]  qc;
		int unsigned n_items, nrec, nq, idx;

		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;

		// lookups on an empty table
		queue_req(CMD_P2L, '0, '0, '0, '0);
		queue_req(CMD_L2P, {PAGE_W{1'b1}}, '0, '0, '0);
		queue_req(CMD_NEXT, '0, '0, '0, '0);
		// records that must be dropped: wrong kind, ending at 1 MB, too short after
		// rounding, rounded start past the top of the address space
		queue_req(CMD_INSERT, '0, 64'h0020_0000, 64'h0010_0000, '1);
		queue_req(CMD_INSERT, '0, '0, ONE_MB, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'h0200_0001, 64'h0fff, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'hffff_ffff_ffff_f001, '1, KIND_USABLE);
		for (int c = CMD_CLEAR + 1; c < 8; c++)
			queue_req(CMD_W'(c), {PAGE_W{1'b1}}, '1, '1, '1);
		// low start with a length that saturates: one region covers almost everything
		queue_req(CMD_INSERT, '0, 64'h1000, '1, KIND_USABLE);
		queue_req(CMD_P2L, {PAGE_W{1'b1}}, '0, '0, '0);
		queue_req(CMD_NEXT, {{(PAGE_W-1){1'b1}}, 1'b0}, '0, '0, '0);
		queue_req(CMD_L2P, {{(PAGE_W-1){1'b1}}, 1'b0}, '0, '0, '0);
		queue_req(CMD_CLEAR, '0, '0, '0, '0);
		// end wraps past 2^64 but the record is kept; short record; equal starts;
		// low start without saturation; an ordinary region
		queue_req(CMD_INSERT, '0, 64'hffff_ffff_ffff_0000, 64'h0002_0000, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'h0020_0800, 64'h1000, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'h0020_1000, 64'h3000, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'h0005_0000, 64'h0020_0000, KIND_USABLE);
		queue_req(CMD_INSERT, '0, 64'h0100_0000, 64'h0010_0000, KIND_USABLE);
		queue_req(CMD_P2L, 52'h201, '0, '0, '0);
		queue_req(CMD_NEXT, 52'h24f, '0, '0, '0);
		queue_req(CMD_P2L, {PAGE_W{1'b1}}, '0, '0, '0);
		queue_req(CMD_NEXT, {PAGE_W{1'b1}}, '0, '0, '0);
		queue_req(CMD_L2P, 52'h36f, '0, '0, '0);

		// random part: mostly table builds followed by aimed lookups, some noise
		lin_total = '0;
		while (cmd_q.size() < 1925) begin
			if ($urandom_range(99) < 12) begin
				r64 = {$urandom, $urandom};
				queue_req(CMD_W'($urandom_range(7)), r64[PAGE_W-1:0], {$urandom, $urandom},
					{$urandom, $urandom}, $urandom_range(1) ? KIND_USABLE : $urandom);
			end else begin
				if ($urandom_range(3) == 0) begin
					queue_req(CMD_CLEAR, '0, '0, '0, '0);
					aim_start.delete();
					aim_len.delete();
					lin_total = '0;
				end
				nrec = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 6);
				repeat (nrec) begin
					case ($urandom_range(3))
						0: bp = 64'($urandom_range(0, 'h180));
						1: bp = 64'($urandom_range('h100, 'h4000));
						2: bp = 64'($urandom);
						default: begin
							bp = {$urandom, $urandom};
							bp = bp & PAGE_MASK;
						end
					endcase
					np = 64'(($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 64));
					aim_start.push_back(bp);
					aim_len.push_back(np);
					lin_total = lin_total + np;
					queue_req(CMD_INSERT, '0,
						(bp << 12) | 64'($urandom_range(3) == 0 ? $urandom_range('hfff) : 0),
						(np << 12) | 64'($urandom_range(1) ? $urandom_range('hfff) : 0),
						($urandom_range(19) == 0) ? $urandom : KIND_USABLE);
				end
				nq = $urandom_range(3, 12);
				repeat (nq) begin
					qc = CMD_W'($urandom_range(CMD_P2L, CMD_NEXT));
					r64 = {$urandom, $urandom};
					if ($urandom_range(4) == 0)
						pg = r64[PAGE_W-1:0];
					else if (qc == CMD_L2P) begin
						r64 = r64 % (lin_total + 3);
						pg  = r64[PAGE_W-1:0];
					end else begin
						idx = $urandom_range(aim_start.size() - 1);
						r64 = aim_start[idx] + r64 % (aim_len[idx] + 2);
						pg  = r64[PAGE_W-1:0];
					end
					queue_req(qc, pg, '0, '0, '0);
				end
			end
		end
		n_items = cmd_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (acc_cnt != n_items || reply_q.size() != 0)
			@(posedge clk);
		// wait past the longest request to catch any stray result
		repeat (100) @(posedge clk);
		if (!failed)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mrmt_pkg.sv
hw/rtl/mrmt_ram.sv
hw/rtl/mrmt_alu.sv
hw/rtl/mrmt_seq.sv
hw/rtl/memory_region_map_translator.sv
tb/sv/memory_region_map_translator_test.sv
